>>> rtl/waee_pkg.sv
// ----------------------------------------------------------------------------
// waee_pkg
// Shared types and constants for the wheel acceleration estimator.
// ----------------------------------------------------------------------------
package waee_pkg;

   localparam int VEL_W   = 24;  // velocity, Q15.8
   localparam int TIME_W  = 32;  // millisecond timestamp
   localparam int EST_W   = 32;  // estimate, Q23.8
   localparam int DV_W    = 25;  // velocity difference
   localparam int MAG_W   = 34;  // |dv| * 1000 and the quotient magnitude
   localparam int DT_W    = 31;  // positive time difference
   localparam int RAW_W   = 35;  // signed raw acceleration
   localparam int DIFF_W  = 36;  // raw minus average
   localparam int SUM_W   = 37;  // average plus correction, before clamping
   localparam int CNT_W   = 6;   // divider step counter
   localparam int SCALE   = 1000;

   typedef logic [1:0] kind_type;
   localparam kind_type KIND_SKIP   = 2'd0;
   localparam kind_type KIND_FIRST  = 2'd1;
   localparam kind_type KIND_UPDATE = 2'd2;

   typedef struct packed {
      logic load;
      logic eval;
      logic mul;
      logic div_step;
      logic sign;
      logic fold;
      logic finish;
   } cmd_type;

   typedef struct packed {
      kind_type kind;
      logic     div_last;
   } stat_type;

endpackage

>>> rtl/waee_ctrl.sv
// ----------------------------------------------------------------------------
// waee_ctrl
// Sequencer: steps one transaction through evaluate, multiply, divide and fold.
// ----------------------------------------------------------------------------
module waee_ctrl import waee_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_tvalid,
   output logic     req_tready,
   input  logic     slot_free,
   input  stat_type stat,
   output cmd_type  cmd
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_EVAL   = 3'd1;
   localparam logic [2:0] ST_MUL    = 3'd2;
   localparam logic [2:0] ST_DIV    = 3'd3;
   localparam logic [2:0] ST_SIGN   = 3'd4;
   localparam logic [2:0] ST_FOLD   = 3'd5;
   localparam logic [2:0] ST_FINISH = 3'd6;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            cmd.eval = 1'b1;
            state_in = (stat.kind == KIND_UPDATE) ? ST_MUL : ST_FINISH;
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (stat.div_last) begin
               state_in = ST_SIGN;
            end
         end
         ST_SIGN: begin
            cmd.sign = 1'b1;
            state_in = ST_FOLD;
         end
         ST_FOLD: begin
            cmd.fold = 1'b1;
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (slot_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> rtl/waee_dpath.sv
// ----------------------------------------------------------------------------
// waee_dpath
// Per-wheel state, restoring divider, average update and result register.
// ----------------------------------------------------------------------------
module waee_dpath import waee_pkg::*; #(
   parameter int WHEEL_COUNT = 2
) (
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output stat_type           stat,
   input  logic               in_wheel,
   input  logic               in_vel_valid,
   input  logic [VEL_W-1:0]   in_velocity,
   input  logic [TIME_W-1:0]  in_now_ms,
   input  logic               rsp_tready,
   output logic               rsp_tvalid,
   output logic [EST_W-1:0]   rsp_estimate,
   output logic               rsp_updated
);

   localparam int IDX_W = (WHEEL_COUNT > 1) ? $clog2(WHEEL_COUNT) : 1;

   // per-wheel state
   logic                     have_ff [WHEEL_COUNT];
   logic        [VEL_W-1:0]  last_vel_ff [WHEEL_COUNT];
   logic        [TIME_W-1:0] last_time_ff [WHEEL_COUNT];
   logic signed [EST_W-1:0]  ema_ff [WHEEL_COUNT];

   // latched transaction
   logic              wheel_ff;
   logic              valid_ff;
   logic [VEL_W-1:0]  vel_ff;
   logic [TIME_W-1:0] now_ff;

   // working registers
   kind_type                 kind_ff;
   logic signed [DV_W-1:0]   dv_ff;
   logic        [DT_W-1:0]   dt_ff;
   logic                     neg_ff;
   logic        [MAG_W-1:0]  quo_ff;
   logic        [DT_W-1:0]   rem_ff;
   logic        [CNT_W-1:0]  cnt_ff;
   logic signed [DIFF_W-1:0] diff_ff;
   logic signed [EST_W-1:0]  new_ema_ff;

   logic              rsp_valid_ff;
   logic [EST_W-1:0]  rsp_est_ff;
   logic              rsp_upd_ff;

   logic                     in_range;
   logic [IDX_W-1:0]         idx;
   logic [TIME_W-1:0]        udt;
   logic signed [DV_W-1:0]   dv;
   kind_type                 kind_now;
   logic [DV_W-1:0]          dv_mag;
   logic [DT_W:0]            trial;
   logic                     ge;
   logic signed [RAW_W-1:0]  raw;
   logic signed [DIFF_W-1:0] adj;
   logic signed [DIFF_W-1:0] delta;
   logic signed [SUM_W-1:0]  sum;
   logic signed [EST_W-1:0]  clamped;
   logic signed [EST_W-1:0]  ema_cur;

   assign in_range = (32'(wheel_ff) < WHEEL_COUNT);
   assign idx      = IDX_W'(wheel_ff);
   assign ema_cur  = ema_ff[idx];

   // classify the sample
   always_comb begin
      udt = now_ff - last_time_ff[idx];
      dv  = $signed({vel_ff[VEL_W-1], vel_ff})
          - $signed({last_vel_ff[idx][VEL_W-1], last_vel_ff[idx]});
      priority if (!in_range || !valid_ff) begin
         kind_now = KIND_SKIP;
      end else if (!have_ff[idx]) begin
         kind_now = KIND_FIRST;
      end else if (vel_ff != last_vel_ff[idx] && udt != '0 && !udt[TIME_W-1]) begin
         kind_now = KIND_UPDATE;
      end else begin
         kind_now = KIND_SKIP;
      end
   end

   assign dv_mag = dv_ff[DV_W-1] ? DV_W'(-dv_ff) : DV_W'(dv_ff);

   // one restoring step: shift in the next dividend bit, subtract if it fits
   assign trial = {rem_ff, quo_ff[MAG_W-1]};
   assign ge    = (trial >= {1'b0, dt_ff});

   assign raw = neg_ff ? -$signed({1'b0, quo_ff}) : $signed({1'b0, quo_ff});

   // divide by four toward zero, add to the average, clamp
   always_comb begin
      adj   = diff_ff + (diff_ff[DIFF_W-1] ? DIFF_W'(3) : DIFF_W'(0));
      delta = adj >>> 2;
      sum   = SUM_W'(ema_cur) + SUM_W'(delta);
      priority if (!sum[SUM_W-1] && (|sum[SUM_W-2:EST_W-1])) begin
         clamped = {1'b0, {(EST_W-1){1'b1}}};
      end else if (sum[SUM_W-1] && !(&sum[SUM_W-2:EST_W-1])) begin
         clamped = {1'b1, {(EST_W-1){1'b0}}};
      end else begin
         clamped = sum[EST_W-1:0];
      end
   end

   assign stat.kind     = kind_now;
   assign stat.div_last = (cnt_ff == CNT_W'(MAG_W - 1));

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         wheel_ff <= in_wheel;
         valid_ff <= in_vel_valid;
         vel_ff   <= in_velocity;
         now_ff   <= in_now_ms;
      end
      if (cmd.eval) begin
         kind_ff <= kind_now;
         dv_ff   <= dv;
         dt_ff   <= udt[DT_W-1:0];
      end
      if (cmd.mul) begin
         neg_ff <= dv_ff[DV_W-1];
         quo_ff <= MAG_W'(dv_mag) * MAG_W'(SCALE);
         rem_ff <= '0;
         cnt_ff <= '0;
      end
      if (cmd.div_step) begin
         rem_ff <= ge ? DT_W'(trial - {1'b0, dt_ff}) : trial[DT_W-1:0];
         quo_ff <= {quo_ff[MAG_W-2:0], ge};
         cnt_ff <= cnt_ff + CNT_W'(1);
      end
      if (cmd.sign) begin
         diff_ff <= DIFF_W'(raw) - DIFF_W'(ema_cur);
      end
      if (cmd.fold) begin
         new_ema_ff <= clamped;
      end
      if (cmd.finish) begin
         rsp_upd_ff <= (kind_ff == KIND_UPDATE);
         if (!in_range) begin
            rsp_est_ff <= '0;
         end else if (kind_ff == KIND_UPDATE) begin
            rsp_est_ff <= new_ema_ff;
         end else begin
            rsp_est_ff <= ema_cur;
         end
      end
   end

   // wheel state and result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WHEEL_COUNT; i++) begin
            have_ff[i]      <= 1'b0;
            last_vel_ff[i]  <= '0;
            last_time_ff[i] <= '0;
            ema_ff[i]       <= '0;
         end
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.finish && in_range && kind_ff != KIND_SKIP) begin
            have_ff[idx]      <= 1'b1;
            last_vel_ff[idx]  <= vel_ff;
            last_time_ff[idx] <= now_ff;
            if (kind_ff == KIND_UPDATE) begin
               ema_ff[idx] <= new_ema_ff;
            end
         end
         if (cmd.finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_estimate = rsp_est_ff;
   assign rsp_updated  = rsp_upd_ff;

endmodule

>>> rtl/wheel_accel_ema_estimator_core.sv
// ----------------------------------------------------------------------------
// wheel_accel_ema_estimator_core
// Per-wheel acceleration estimate, exponential moving average of dv*1000/dt.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_): one transaction per velocity report. req_tuser
//   carries the wheel index and a sample-present flag, req_tdata carries the
//   Q15.8 velocity and the wrapping millisecond timestamp.
//   Response channel (rsp_): exactly one transaction per request, in order,
//   holding the wheel's Q23.8 estimate and an updated flag in rsp_tuser.
//   A sample that updates the average runs from accept to rsp_tvalid through
//   evaluate, multiply, 34 steps of the shared restoring divider, subtract,
//   fold and write back; every other request runs evaluate and write back.
//   One request is in flight at a time, so a new request is accepted only
//   after the current one has been written back.
//   The response sits in an output register, so the next request is accepted
//   while an earlier response still waits; a stalled receiver holds the
//   block only at write back, until that register frees up.
//   Reset clears every wheel's history and average and drops any response.
// ----------------------------------------------------------------------------
module wheel_accel_ema_estimator_core import waee_pkg::*; #(
   parameter int WHEEL_COUNT = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,   // [23:0] velocity, [55:24] now_ms
   input  logic [1:0]  req_tuser,   // [0] wheel, [1] vel_valid
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] accel_estimate
   output logic        rsp_tuser    // [0] updated
);

   cmd_type  cmd;
   stat_type stat;
   logic     slot_free;

   // the result register can take a new response when empty or draining
   assign slot_free = !rsp_tvalid || rsp_tready;

   waee_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .slot_free  (slot_free),
      .stat       (stat),
      .cmd        (cmd)
   );

   waee_dpath #(
      .WHEEL_COUNT (WHEEL_COUNT)
   ) u_dpath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .stat         (stat),
      .in_wheel     (req_tuser[0]),
      .in_vel_valid (req_tuser[1]),
      .in_velocity  (req_tdata[VEL_W-1:0]),
      .in_now_ms    (req_tdata[VEL_W+TIME_W-1:VEL_W]),
      .rsp_tready   (rsp_tready),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_estimate (rsp_tdata),
      .rsp_updated  (rsp_tuser)
   );

   // busy right after taking a request
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request accepted while a transaction is in flight");

   // the sequencer issues at most one command per cycle
   assert property (@(posedge clock) disable iff (reset) $onehot0(cmd))
      else $error("more than one datapath command at once");

   // a response appears only after write back
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(cmd.finish))
      else $error("response raised without write back");

   // write back never overruns a stalled response
   assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> slot_free)
      else $error("write back while response register is blocked");

endmodule
